### design/button_debounce_hold_detector_core_defines.svh
// Assertion macros for the button debounce and hold detector core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BUTTON_DEBOUNCE_HOLD_DETECTOR_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BDHD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bdhd assertion failed");

// next-cycle implication, disabled during reset
`define BDHD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bdhd assertion failed");

`endif

### design/bdhd_pkg.sv
// Shared types, constants and time compare for the button debounce core.
// No dependencies.
`default_nettype none

package bdhd_pkg;

    localparam int MAX_BUTTONS = 8;
    localparam int PIN_W       = 4;
    localparam int TIME_W      = 32;
    localparam int HOLD_W      = 31;
    localparam int ID_W        = 2;
    localparam int DEB_W       = 16;
    localparam int REQ_W       = 2;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 8;
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

    typedef enum logic [REQ_W-1:0] {
        REQ_POLL   = 2'd0,
        REQ_HOLD   = 2'd1,
        REQ_RESYNC = 2'd2
    } req_t;

    typedef struct packed {
        req_t              req;
        logic [TIME_W-1:0] now_ms;
        logic [PIN_W-1:0]  pin_levels;
        logic [PIN_W-1:0]  edge_flags;
        logic [ID_W-1:0]   button_id;
        logic [HOLD_W-1:0] hold_ms;
    } item_t;

    function automatic logic elapsed_at_least(input logic [TIME_W-1:0] now,
                                              input logic [TIME_W-1:0] start,
                                              input logic [TIME_W-1:0] limit);
        logic [TIME_W-1:0] diff;
        diff = now - start;
        return !diff[TIME_W-1] && (diff >= limit);
    endfunction

endpackage

`default_nettype wire

### design/button_debounce_hold_detector_core.sv
// Debounces NUM_BUTTONS buttons from timestamped poll items and answers
// once-per-press hold queries. One item is taken every clock cycle unless
// input stalls. An item lands in the input register at its transfer; all
// buttons update side by side from it and the result is loaded into the
// output register as the item advances. The output register parts the two
// sides, so one more item is taken while a result waits; input stalls only
// when both registers are full. The debounce_ms register is written
// through cfg_* (always ready, reset 50); the user must write it only while
// no item is in flight, as the block does not enforce this. Depends on
// bdhd_pkg, bdhd_lane and the defines header.
`default_nettype none

`include "button_debounce_hold_detector_core_defines.svh"

module button_debounce_hold_detector_core #(
    parameter int NUM_BUTTONS = 4
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // now_ms[31:0], pin_levels[35:32], edge_flags[39:36], button_id[41:40],
    // hold_ms[72:42], zero fill[79:73]
    input  wire logic [bdhd_pkg::IN_TDATA_W-1:0]     s_tdata,
    // req_type[1:0]
    input  wire logic [bdhd_pkg::REQ_W-1:0]          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // stable_levels[3:0], hold_fired[4], zero fill[7:5]
    output logic [bdhd_pkg::OUT_TDATA_W-1:0]         m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bdhd_pkg::DEB_W-1:0]          cfg_data
);

    localparam int MAXB = bdhd_pkg::MAX_BUTTONS;

    logic                              in_valid_reg;
    bdhd_pkg::item_t                   in_item_reg;
    bdhd_pkg::item_t                   s_item;
    logic                              m_valid_reg;
    logic [bdhd_pkg::OUT_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [bdhd_pkg::DEB_W-1:0]        debounce_reg;
    logic                              advance;
    logic                              s_xfer;
    logic [MAXB-1:0]                   pin_ext, edge_ext, stable_ext;
    logic [NUM_BUTTONS-1:0]            stable_vec, fire_vec;
    logic                              hold_fired;

    assign s_item.req        = bdhd_pkg::req_t'(s_tuser);
    assign s_item.now_ms     = s_tdata[31:0];
    assign s_item.pin_levels = s_tdata[35:32];
    assign s_item.edge_flags = s_tdata[39:36];
    assign s_item.button_id  = s_tdata[41:40];
    assign s_item.hold_ms    = s_tdata[72:42];

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= bdhd_pkg::DEBOUNCE_RESET;
        end else if (cfg_valid) begin
            debounce_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= s_item;
        end
    end

    assign pin_ext  = MAXB'(in_item_reg.pin_levels);
    assign edge_ext = MAXB'(in_item_reg.edge_flags);

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        bdhd_lane #(
            .LANE (i)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (advance),
            .item        (in_item_reg),
            .level       (pin_ext[i]),
            .edge_seen   (edge_ext[i]),
            .debounce_ms (debounce_reg),
            .stable_next (stable_vec[i]),
            .fire        (fire_vec[i])
        );
    end

    always_comb begin
        stable_ext                  = '0;
        stable_ext[NUM_BUTTONS-1:0] = stable_vec;
    end

    assign hold_fired  = |fire_vec;
    assign m_data_next = {3'b000, hold_fired, stable_ext[bdhd_pkg::PIN_W-1:0]};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    `BDHD_ASSERT_IMP(a_fire_only_on_query, aclk, aresetn, advance && hold_fired, in_item_reg.req == bdhd_pkg::REQ_HOLD)
    `BDHD_ASSERT_IMP(a_fire_one_button, aclk, aresetn, advance, $onehot0(fire_vec))
    `BDHD_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready, in_valid_reg && m_valid_reg && !m_tready)
    `BDHD_ASSERT_NXT(a_result_follows, aclk, aresetn, advance, m_tvalid && (m_tdata == $past(m_data_next)))

endmodule

`default_nettype wire

### design/bdhd_lane.sv
// Per-button debounce and hold state with its combinational next-state update.
// Depends on bdhd_pkg.
`default_nettype none

module bdhd_lane #(
    parameter int LANE = 0
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire bdhd_pkg::item_t              item,
    input  wire logic                         level,
    input  wire logic                         edge_seen,
    input  wire logic [bdhd_pkg::DEB_W-1:0]   debounce_ms,
    output logic                              stable_next,
    output logic                              fire
);

    logic                            raw_reg, raw_next;
    logic                            stable_reg;
    logic [bdhd_pkg::TIME_W-1:0]     since_reg, since_next;
    logic [bdhd_pkg::TIME_W-1:0]     press_reg, press_next;
    logic                            done_reg, done_next;
    logic                            chg;
    logic                            sel;

    assign sel = (int'(item.button_id) == LANE);

    always_comb begin
        raw_next    = raw_reg;
        since_next  = since_reg;
        press_next  = press_reg;
        done_next   = done_reg;
        stable_next = stable_reg;
        fire        = 1'b0;
        chg         = edge_seen || (level != raw_reg);
        unique case (item.req)
            bdhd_pkg::REQ_POLL: begin
                if (chg) begin
                    raw_next   = level;
                    since_next = item.now_ms;
                end
                if ((raw_next != stable_reg) &&
                    bdhd_pkg::elapsed_at_least(item.now_ms, since_next,
                                               bdhd_pkg::TIME_W'(debounce_ms))) begin
                    stable_next = raw_next;
                    if (raw_next) begin
                        press_next = since_next;
                        done_next  = 1'b0;
                    end
                end
            end
            bdhd_pkg::REQ_HOLD: begin
                if (sel && stable_reg && !done_reg &&
                    bdhd_pkg::elapsed_at_least(item.now_ms, press_reg,
                                               bdhd_pkg::TIME_W'(item.hold_ms))) begin
                    fire      = 1'b1;
                    done_next = 1'b1;
                end
            end
            bdhd_pkg::REQ_RESYNC: begin
                raw_next    = level;
                stable_next = level;
                since_next  = item.now_ms;
                press_next  = item.now_ms;
                done_next   = level;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg    <= 1'b0;
            stable_reg <= 1'b0;
            since_reg  <= '0;
            press_reg  <= '0;
            done_reg   <= 1'b0;
        end else if (en) begin
            raw_reg    <= raw_next;
            stable_reg <= stable_next;
            since_reg  <= since_next;
            press_reg  <= press_next;
            done_reg   <= done_next;
        end
    end

endmodule

`default_nettype wire
